>>> src/vsmt_pkg.sv
package vsmt_pkg;

  localparam int FIELD_BITS_DEFAULT = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

>>> src/vsmt_parse.sv
module vsmt_parse #(
  parameter int FIELD_BITS = vsmt_pkg::FIELD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   text_byte,
  input  logic                         line_end,
  output logic                         ver_valid,
  input  logic                         ver_ready,
  output logic signed [FIELD_BITS-1:0] ver_major,
  output logic signed [FIELD_BITS-1:0] ver_minor,
  output logic signed [FIELD_BITS-1:0] ver_patch
);

  localparam int MAG_W  = FIELD_BITS - 1;
  localparam int PROD_W = MAG_W + 4;

  typedef enum logic [1:0] {FLD_MAJOR, FLD_MINOR, FLD_PATCH, FLD_DONE} field_t;
  typedef enum logic [1:0] {PH_SKIP, PH_SIGNED, PH_DIGITS, PH_STOP} phase_t;

  function automatic logic signed [FIELD_BITS-1:0] to_value(input logic neg,
                                                           input logic [MAG_W-1:0] mag);
    logic signed [FIELD_BITS-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // input register
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       end_q;

  // conversion state
  field_t                       field_sel, field_sel_next;
  phase_t                       phase, phase_next;
  logic                         neg, neg_next;
  logic [MAG_W-1:0]             acc, acc_next;
  logic signed [FIELD_BITS-1:0] line_major, line_major_next;
  logic signed [FIELD_BITS-1:0] line_minor, line_minor_next;

  logic                         advance;
  logic                         is_digit, is_space, is_sign;
  logic [PROD_W-1:0]            acc_ext, prod;
  logic signed [FIELD_BITS-1:0] cur_value, cur_value_next;

  assign advance  = byte_valid && (!end_q || !ver_valid || ver_ready);
  assign in_ready = !byte_valid || advance;

  assign is_digit = (byte_q >= vsmt_pkg::CH_ZERO) && (byte_q <= vsmt_pkg::CH_NINE);
  assign is_space = (byte_q == vsmt_pkg::CH_SPACE) ||
                    ((byte_q >= vsmt_pkg::CH_TAB) && (byte_q <= vsmt_pkg::CH_CR));
  assign is_sign  = (byte_q == vsmt_pkg::CH_PLUS) || (byte_q == vsmt_pkg::CH_MINUS);

  // acc * 10 + digit, saturating at the magnitude limit
  assign acc_ext   = {4'b0, acc};
  assign prod      = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W-4){1'b0}}, byte_q[3:0]};
  assign cur_value = to_value(neg, acc);

  always_comb begin
    field_sel_next  = field_sel;
    phase_next      = phase;
    neg_next        = neg;
    acc_next        = acc;
    line_major_next = line_major;
    line_minor_next = line_minor;
    if (field_sel != FLD_DONE) begin
      if (byte_q == vsmt_pkg::CH_NUL) begin
        if (field_sel == FLD_MAJOR) begin
          line_major_next = cur_value;
          line_minor_next = '0;
          neg_next        = 1'b0;
          acc_next        = '0;
        end else if (field_sel == FLD_MINOR) begin
          line_minor_next = cur_value;
          neg_next        = 1'b0;
          acc_next        = '0;
        end
        phase_next     = PH_STOP;
        field_sel_next = FLD_DONE;
      end else if (byte_q == vsmt_pkg::CH_DOT &&
                   (field_sel == FLD_MAJOR || field_sel == FLD_MINOR)) begin
        if (field_sel == FLD_MAJOR) begin
          line_major_next = cur_value;
          field_sel_next  = FLD_MINOR;
        end else begin
          line_minor_next = cur_value;
          field_sel_next  = FLD_PATCH;
        end
        phase_next = PH_SKIP;
        neg_next   = 1'b0;
        acc_next   = '0;
      end else if (phase != PH_STOP) begin
        if (is_digit) begin
          acc_next   = (prod > {4'b0, {MAG_W{1'b1}}}) ? {MAG_W{1'b1}} : prod[MAG_W-1:0];
          phase_next = PH_DIGITS;
        end else if (phase == PH_SKIP && is_space) begin
          phase_next = PH_SKIP;
        end else if (phase == PH_SKIP && is_sign) begin
          neg_next   = (byte_q == vsmt_pkg::CH_MINUS);
          phase_next = PH_SIGNED;
        end else begin
          phase_next = PH_STOP;
        end
      end
    end
  end

  assign cur_value_next = to_value(neg_next, acc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      ver_valid  <= 1'b0;
      field_sel  <= FLD_MAJOR;
      phase      <= PH_SKIP;
      neg        <= 1'b0;
      acc        <= '0;
      line_major <= '0;
      line_minor <= '0;
    end else begin
      if (ver_valid && ver_ready) begin
        ver_valid <= 1'b0;
      end
      if (advance) begin
        if (end_q) begin
          ver_valid  <= 1'b1;
          field_sel  <= FLD_MAJOR;
          phase      <= PH_SKIP;
          neg        <= 1'b0;
          acc        <= '0;
          line_major <= '0;
          line_minor <= '0;
        end else begin
          field_sel  <= field_sel_next;
          phase      <= phase_next;
          neg        <= neg_next;
          acc        <= acc_next;
          line_major <= line_major_next;
          line_minor <= line_minor_next;
        end
      end
      if (in_ready) begin
        byte_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= text_byte;
      end_q  <= line_end;
    end
    if (advance && end_q) begin
      unique case (field_sel_next)
        FLD_MAJOR: begin
          ver_major <= cur_value_next;
          ver_minor <= '0;
          ver_patch <= '0;
        end
        FLD_MINOR: begin
          ver_major <= line_major_next;
          ver_minor <= cur_value_next;
          ver_patch <= '0;
        end
        default: begin
          ver_major <= line_major_next;
          ver_minor <= line_minor_next;
          ver_patch <= cur_value_next;
        end
      endcase
    end
  end

endmodule

>>> src/vsmt_max.sv
module vsmt_max #(
  parameter int FIELD_BITS = vsmt_pkg::FIELD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ver_valid,
  output logic                         ver_ready,
  input  logic signed [FIELD_BITS-1:0] ver_major,
  input  logic signed [FIELD_BITS-1:0] ver_minor,
  input  logic signed [FIELD_BITS-1:0] ver_patch,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FIELD_BITS-1:0] best_major,
  output logic signed [FIELD_BITS-1:0] best_minor,
  output logic signed [FIELD_BITS-1:0] best_patch,
  output logic                         replaced
);

  logic signed [FIELD_BITS-1:0] max_major, max_minor, max_patch;
  logic                         take, larger;

  assign ver_ready = !out_valid || out_ready;
  assign take      = ver_valid && ver_ready;

  always_comb begin
    if (ver_major != max_major) begin
      larger = ver_major > max_major;
    end else if (ver_minor != max_minor) begin
      larger = ver_minor > max_minor;
    end else begin
      larger = ver_patch > max_patch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      max_major <= '0;
      max_minor <= '0;
      max_patch <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
        if (larger) begin
          max_major <= ver_major;
          max_minor <= ver_minor;
          max_patch <= ver_patch;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_major <= larger ? ver_major : max_major;
      best_minor <= larger ? ver_minor : max_minor;
      best_patch <= larger ? ver_patch : max_patch;
      replaced   <= larger;
    end
  end

endmodule

>>> src/version_string_max_tracker.sv
// channel  handshake            payload
// input    in_valid/in_ready    text_byte, line_end
// output   out_valid/out_ready  best_major, best_minor, best_patch, replaced
//
// one byte per cycle unless the input stalls; after a line's last byte is accepted its
// result passes the input register, then line version register, then result register
// rst is synchronous and returns the largest version to 0.0.0
// a stalled output holds the result while bytes of the next line keep flowing;
// input stalls only when a line end meets a full result path (two results waiting)

module version_string_max_tracker #(
  parameter int FIELD_BITS = vsmt_pkg::FIELD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   text_byte,
  input  logic                         line_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FIELD_BITS-1:0] best_major,
  output logic signed [FIELD_BITS-1:0] best_minor,
  output logic signed [FIELD_BITS-1:0] best_patch,
  output logic                         replaced
);

  logic                         ver_valid, ver_ready;
  logic signed [FIELD_BITS-1:0] ver_major, ver_minor, ver_patch;

  vsmt_parse #(.FIELD_BITS(FIELD_BITS)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .line_end  (line_end),
    .ver_valid (ver_valid),
    .ver_ready (ver_ready),
    .ver_major (ver_major),
    .ver_minor (ver_minor),
    .ver_patch (ver_patch)
  );

  vsmt_max #(.FIELD_BITS(FIELD_BITS)) u_max (
    .clk        (clk),
    .rst        (rst),
    .ver_valid  (ver_valid),
    .ver_ready  (ver_ready),
    .ver_major  (ver_major),
    .ver_minor  (ver_minor),
    .ver_patch  (ver_patch),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_major (best_major),
    .best_minor (best_minor),
    .best_patch (best_patch),
    .replaced   (replaced)
  );

endmodule
